@@ src/gdbd_pkg.sv @@
// ----------------------------------------------------------------------------
// gdbd_pkg
// Types, constants and calendar helpers for the days-between-dates block.
// ----------------------------------------------------------------------------
package gdbd_pkg;

    // input word layout in s_axis_tdata
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned IN_YEAR_W  = 14;
    localparam int unsigned IN_MONTH_W = 4;
    localparam int unsigned IN_DAY_W   = 5;

    localparam int unsigned SY_LO = 0;
    localparam int unsigned SM_LO = SY_LO + IN_YEAR_W;
    localparam int unsigned SD_LO = SM_LO + IN_MONTH_W;
    localparam int unsigned EY_LO = SD_LO + IN_DAY_W;
    localparam int unsigned EM_LO = EY_LO + IN_YEAR_W;
    localparam int unsigned ED_LO = EM_LO + IN_MONTH_W;

    localparam int unsigned CNT_W      = 22;
    localparam int unsigned OUT_DATA_W = 24;
    localparam logic [CNT_W-1:0] DAY_COUNT_MAX = {CNT_W{1'b1}};

    // working widths: years up to 32767, serial day numbers below 2^24
    localparam int unsigned YEAR_W   = 15;
    localparam int unsigned SERIAL_W = 24;
    localparam int unsigned CUM_W    = 9;

    // floor(x / 100) = (x * 5243) >> 19, exact for x < 43690
    localparam int unsigned RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
    localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [IN_MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [IN_MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [IN_MONTH_W-1:0] MONTH_LAST  = 4'd12;

    localparam logic [IN_DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // days before the first of each month in a common year
    localparam logic [CUM_W-1:0] CUM_DAYS [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    function automatic logic [IN_DAY_W-1:0] month_days(
        input logic [IN_MONTH_W-1:0] m,
        input logic                  leap
    );
        logic [IN_MONTH_W-1:0] idx;
        idx = m - MONTH_FIRST;
        if (m == MONTH_FEB)
        begin
            return leap ? 5'd29 : 5'd28;
        end
        return MONTH_LEN[idx];
    endfunction

    function automatic logic [CUM_W-1:0] days_before(input logic [IN_MONTH_W-1:0] m);
        logic [IN_MONTH_W-1:0] idx;
        idx = m - MONTH_FIRST;
        return CUM_DAYS[idx];
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DIV,
        ST_BASE,
        ST_SERIAL,
        ST_DIFF,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the input word
        logic sel_end;   // 0: start date, 1: end date
        logic clamp;
        logic div;
        logic base;
        logic serial;
        logic diff;
        logic load_out;
    } dp_cmd_t;

endpackage

@@ src/gdbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// gdbd_ctrl
// Sequencer: walks both dates through the datapath, then hands the count to
// the output register.
// ----------------------------------------------------------------------------
module gdbd_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output gdbd_pkg::dp_cmd_t  cmd
);

    gdbd_pkg::state_t state_reg;
    gdbd_pkg::state_t state_next;
    logic             sel_reg;
    logic             sel_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdbd_pkg::ST_IDLE;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.sel_end    = sel_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            gdbd_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                sel_next    = 1'b0;
                if (in_valid)
                begin
                    state_next = gdbd_pkg::ST_CLAMP;
                end
            end
            gdbd_pkg::ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = gdbd_pkg::ST_DIV;
            end
            gdbd_pkg::ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = gdbd_pkg::ST_BASE;
            end
            gdbd_pkg::ST_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = gdbd_pkg::ST_SERIAL;
            end
            gdbd_pkg::ST_SERIAL:
            begin
                cmd.serial = 1'b1;
                if (sel_reg)
                begin
                    state_next = gdbd_pkg::ST_DIFF;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = gdbd_pkg::ST_CLAMP;
                end
            end
            gdbd_pkg::ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = gdbd_pkg::ST_DONE;
            end
            gdbd_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = gdbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gdbd_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while full");

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped under stall");

    // an accepted word starts the start-date pass
    a_start_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == gdbd_pkg::ST_CLAMP && !sel_reg))
        else $error("accepted word did not start the start-date pass");

    // the end-date pass always precedes the subtraction
    a_diff_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.diff |-> $past(cmd.serial && cmd.sel_end))
        else $error("count formed before end date was done");

endmodule

@@ src/gdbd_dp.sv @@
// ----------------------------------------------------------------------------
// gdbd_dp
// Datapath: clamps a date, forms its serial day number over three steps,
// subtracts the two serials and holds the result word.
// ----------------------------------------------------------------------------
module gdbd_dp
#(
    parameter int unsigned MAX_YEAR = 9999
)
(
    input  logic                                 clk,
    input  gdbd_pkg::dp_cmd_t                    cmd,
    input  logic [gdbd_pkg::IN_DATA_W-1:0]       in_data,
    input  logic                                 in_include,
    output logic [gdbd_pkg::CNT_W-1:0]           day_count
);

    localparam logic [gdbd_pkg::YEAR_W-1:0] MaxYear = gdbd_pkg::YEAR_W'(MAX_YEAR);

    // captured input word
    logic [gdbd_pkg::IN_YEAR_W-1:0]  sy_reg, ey_reg;
    logic [gdbd_pkg::IN_MONTH_W-1:0] sm_reg, em_reg;
    logic [gdbd_pkg::IN_DAY_W-1:0]   sd_reg, ed_reg;
    logic                            incl_reg;

    // per-date working registers
    logic [gdbd_pkg::YEAR_W-1:0]     y_reg;
    logic [gdbd_pkg::IN_MONTH_W-1:0] m_reg;
    logic [gdbd_pkg::IN_DAY_W-1:0]   d_reg;
    logic [gdbd_pkg::QUOT_W-1:0]     q100p_reg, q400p_reg, q100y_reg;
    logic [gdbd_pkg::SERIAL_W-1:0]   base_reg;
    logic                            leap_reg;
    logic [gdbd_pkg::SERIAL_W-1:0]   s_ser_reg, e_ser_reg;
    logic [gdbd_pkg::CNT_W-1:0]      cnt_reg, out_reg;

    logic [gdbd_pkg::IN_YEAR_W-1:0]  raw_y;
    logic [gdbd_pkg::IN_MONTH_W-1:0] raw_m;
    logic [gdbd_pkg::YEAR_W-1:0]     raw_y_ext, y_next;
    logic [gdbd_pkg::IN_MONTH_W-1:0] m_next;
    logic [gdbd_pkg::YEAR_W-1:0]     p;
    logic [gdbd_pkg::YEAR_W-1:0]     p4;
    logic [gdbd_pkg::PROD_W-1:0]     prod_p, prod_p4, prod_y;
    logic [gdbd_pkg::YEAR_W-1:0]     y_hund;
    logic                            div100, leap_next;
    logic [gdbd_pkg::SERIAL_W-1:0]   base_next;
    logic [gdbd_pkg::IN_DAY_W-1:0]   lim, d_c;
    logic [gdbd_pkg::SERIAL_W-1:0]   serial_next;
    logic [gdbd_pkg::SERIAL_W-1:0]   diff, cnt_wide;
    logic [gdbd_pkg::CNT_W-1:0]      cnt_next;

    // clamp
    always_comb
    begin
        raw_y     = cmd.sel_end ? ey_reg : sy_reg;
        raw_m     = cmd.sel_end ? em_reg : sm_reg;
        raw_y_ext = gdbd_pkg::YEAR_W'(raw_y);
        if (raw_y_ext == '0)
        begin
            y_next = gdbd_pkg::YEAR_W'(1);
        end
        else if (raw_y_ext > MaxYear)
        begin
            y_next = MaxYear;
        end
        else
        begin
            y_next = raw_y_ext;
        end
        if (raw_m == '0)
        begin
            m_next = gdbd_pkg::MONTH_FIRST;
        end
        else if (raw_m > gdbd_pkg::MONTH_LAST)
        begin
            m_next = gdbd_pkg::MONTH_LAST;
        end
        else
        begin
            m_next = raw_m;
        end
    end

    // divisions by 100 and 400 through the reciprocal
    assign p       = y_reg - gdbd_pkg::YEAR_W'(1);
    assign p4      = p >> 2;
    assign prod_p  = gdbd_pkg::PROD_W'(p)  * gdbd_pkg::PROD_W'(gdbd_pkg::RECIP_100);
    assign prod_p4 = gdbd_pkg::PROD_W'(p4) * gdbd_pkg::PROD_W'(gdbd_pkg::RECIP_100);
    assign prod_y  = gdbd_pkg::PROD_W'(y_reg) * gdbd_pkg::PROD_W'(gdbd_pkg::RECIP_100);

    // leap test and day count up to Jan 1
    always_comb
    begin
        y_hund    = gdbd_pkg::YEAR_W'(q100y_reg) * gdbd_pkg::YEAR_W'(100);
        div100    = (y_hund == y_reg);
        leap_next = ((y_reg[1:0] == 2'b00) && !div100) || (div100 && q100y_reg[1:0] == 2'b00);
        base_next = gdbd_pkg::SERIAL_W'(p) * gdbd_pkg::SERIAL_W'(365)
                  + gdbd_pkg::SERIAL_W'(p4)
                  - gdbd_pkg::SERIAL_W'(q100p_reg)
                  + gdbd_pkg::SERIAL_W'(q400p_reg);
    end

    // month and day
    always_comb
    begin
        lim = gdbd_pkg::month_days(m_reg, leap_reg);
        if (d_reg == '0)
        begin
            d_c = gdbd_pkg::IN_DAY_W'(1);
        end
        else if (d_reg > lim)
        begin
            d_c = lim;
        end
        else
        begin
            d_c = d_reg;
        end
        serial_next = base_reg
                    + gdbd_pkg::SERIAL_W'(gdbd_pkg::days_before(m_reg))
                    + gdbd_pkg::SERIAL_W'(leap_reg && (m_reg > gdbd_pkg::MONTH_FEB))
                    + gdbd_pkg::SERIAL_W'(d_c);
    end

    // difference, include flag, saturation
    always_comb
    begin
        diff     = (s_ser_reg < e_ser_reg) ? (e_ser_reg - s_ser_reg) : '0;
        cnt_wide = diff + gdbd_pkg::SERIAL_W'(incl_reg);
        if (cnt_wide > gdbd_pkg::SERIAL_W'(gdbd_pkg::DAY_COUNT_MAX))
        begin
            cnt_next = gdbd_pkg::DAY_COUNT_MAX;
        end
        else
        begin
            cnt_next = cnt_wide[gdbd_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sy_reg   <= in_data[gdbd_pkg::SY_LO +: gdbd_pkg::IN_YEAR_W];
            sm_reg   <= in_data[gdbd_pkg::SM_LO +: gdbd_pkg::IN_MONTH_W];
            sd_reg   <= in_data[gdbd_pkg::SD_LO +: gdbd_pkg::IN_DAY_W];
            ey_reg   <= in_data[gdbd_pkg::EY_LO +: gdbd_pkg::IN_YEAR_W];
            em_reg   <= in_data[gdbd_pkg::EM_LO +: gdbd_pkg::IN_MONTH_W];
            ed_reg   <= in_data[gdbd_pkg::ED_LO +: gdbd_pkg::IN_DAY_W];
            incl_reg <= in_include;
        end
        if (cmd.clamp)
        begin
            y_reg <= y_next;
            m_reg <= m_next;
            d_reg <= cmd.sel_end ? ed_reg : sd_reg;
        end
        if (cmd.div)
        begin
            q100p_reg <= prod_p[gdbd_pkg::PROD_W-1:gdbd_pkg::RECIP_SHIFT];
            q400p_reg <= prod_p4[gdbd_pkg::PROD_W-1:gdbd_pkg::RECIP_SHIFT];
            q100y_reg <= prod_y[gdbd_pkg::PROD_W-1:gdbd_pkg::RECIP_SHIFT];
        end
        if (cmd.base)
        begin
            base_reg <= base_next;
            leap_reg <= leap_next;
        end
        if (cmd.serial)
        begin
            if (cmd.sel_end)
            begin
                e_ser_reg <= serial_next;
            end
            else
            begin
                s_ser_reg <= serial_next;
            end
        end
        if (cmd.diff)
        begin
            cnt_reg <= cnt_next;
        end
        if (cmd.load_out)
        begin
            out_reg <= cnt_reg;
        end
    end

    assign day_count = out_reg;

endmodule

@@ src/gregorian_days_between_dates.sv @@
// ----------------------------------------------------------------------------
// gregorian_days_between_dates
// Days from a start date to an end date in the proleptic Gregorian calendar.
// ----------------------------------------------------------------------------
// Input stream: one word per date pair. s_axis_tdata carries start year,
// month, day, then end year, month, day; s_axis_tuser carries the include
// flag, which adds one so that the end day itself is counted.
// Output stream: one word per input, m_axis_tdata carries the day count,
// zero when the start date is not before the end date, plus the flag.
// Out-of-range fields are pulled into range (year 1..MAX_YEAR, month 1..12,
// day 1..month length); the count saturates at the 22-bit maximum.
// Each date passes through the clamp, divide by 100/400, day count up to the
// year, and month and day add steps in turn. The sequencer passes both dates
// through the one date datapath and takes the next word only in idle, after
// the result of the last one is loaded into the output register.
// A finished result sits in the output register; while the receiver stalls,
// the block still accepts and works on the next word and then waits until
// the register is taken. Reset clears the sequencer and the output valid.
// MAX_YEAR may be set from 1 to 32767.
// ----------------------------------------------------------------------------
module gregorian_days_between_dates
#(
    parameter int unsigned MAX_YEAR = 9999
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // start_year, start_month, start_day, end_year, end_month, end_day
    input  logic [gdbd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // include_last
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // day_count
    output logic [gdbd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    gdbd_pkg::dp_cmd_t          cmd;
    logic [gdbd_pkg::CNT_W-1:0] day_count;

    gdbd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    gdbd_dp
    #(
        .MAX_YEAR (MAX_YEAR)
    )
    u_dp
    (
        .clk        (clk),
        .cmd        (cmd),
        .in_data    (s_axis_tdata),
        .in_include (s_axis_tuser[0]),
        .day_count  (day_count)
    );

    assign m_axis_tdata = gdbd_pkg::OUT_DATA_W'(day_count);

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gregorian_days_between_dates: date pairs go in on
// the input stream, and each day count is compared with a calendar model.
// Directed pairs cover the field extremes, the clamped fields, leap and
// century Februaries, and equal, reversed and full-range spans. Random pairs
// follow. Both streams idle at random, and the receiver holds off once.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned MAX_YEAR     = 9999;
    localparam int unsigned RANDOM_PAIRS = 80;
    localparam int unsigned HOLD_AT      = 25;    // results seen before the long hold
    localparam int unsigned HOLD_CYCLES  = 250;
    localparam int unsigned QUIET_LO     = 60;    // no idling on either side in here
    localparam int unsigned QUIET_HI     = 90;
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [gdbd_pkg::IN_YEAR_W-1:0]  sy;
        logic [gdbd_pkg::IN_MONTH_W-1:0] sm;
        logic [gdbd_pkg::IN_DAY_W-1:0]   sd;
        logic [gdbd_pkg::IN_YEAR_W-1:0]  ey;
        logic [gdbd_pkg::IN_MONTH_W-1:0] em;
        logic [gdbd_pkg::IN_DAY_W-1:0]   ed;
        logic                            incl;
        bit                              drain;   // wait for all counts before offering this one
    } date_pair_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [gdbd_pkg::IN_DATA_W-1:0]  s_data = '0;
    logic [0:0]                      s_user = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [gdbd_pkg::OUT_DATA_W-1:0] m_data;

    date_pair_t                  pending[$];
    logic [gdbd_pkg::CNT_W-1:0]  expected_counts[$];
    date_pair_t                  in_flight;
    int unsigned                 accepted = 0;
    int unsigned                 received = 0;
    int unsigned                 mismatches = 0;
    int unsigned                 cycles = 0;
    int unsigned                 hold_left = 0;
    bit                          held = 1'b0;

    gregorian_days_between_dates #(.MAX_YEAR(MAX_YEAR)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    // ------------------------------------------------------------------------
    // calendar model
    // ------------------------------------------------------------------------
    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        case (m)
            gdbd_pkg::MONTH_FEB: return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:         return 30;
            default:             return 31;
        endcase
    endfunction

    // day number with 0001-01-01 as day 1, fields pulled into range first
    function automatic int unsigned day_number(
        input logic [gdbd_pkg::IN_YEAR_W-1:0]  yr,
        input logic [gdbd_pkg::IN_MONTH_W-1:0] mo,
        input logic [gdbd_pkg::IN_DAY_W-1:0]   dy
    );
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned last;
        int unsigned p;
        int unsigned n;
        y = (yr == 0) ? 1 : ((yr > MAX_YEAR) ? MAX_YEAR : yr);
        m = (mo == 0) ? 1 : ((mo > gdbd_pkg::MONTH_LAST) ? gdbd_pkg::MONTH_LAST : mo);
        last = month_length(m, y);
        d = (dy == 0) ? 1 : ((dy > last) ? last : dy);
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++)
        begin
            n += month_length(k, y);
        end
        return n + d;
    endfunction

    function automatic logic [gdbd_pkg::CNT_W-1:0] span_days(input date_pair_t pr);
        int unsigned first;
        int unsigned last;
        longint unsigned cnt;
        first = day_number(pr.sy, pr.sm, pr.sd);
        last  = day_number(pr.ey, pr.em, pr.ed);
        cnt = (first < last) ? (last - first) : 0;
        cnt += pr.incl;
        if (cnt > gdbd_pkg::DAY_COUNT_MAX)
        begin
            cnt = gdbd_pkg::DAY_COUNT_MAX;
        end
        return cnt[gdbd_pkg::CNT_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_pair(
        input int unsigned sy, input int unsigned sm, input int unsigned sd,
        input int unsigned ey, input int unsigned em, input int unsigned ed,
        input bit incl
    );
        date_pair_t pr;
        pr.sy = gdbd_pkg::IN_YEAR_W'(sy);
        pr.sm = gdbd_pkg::IN_MONTH_W'(sm);
        pr.sd = gdbd_pkg::IN_DAY_W'(sd);
        pr.ey = gdbd_pkg::IN_YEAR_W'(ey);
        pr.em = gdbd_pkg::IN_MONTH_W'(em);
        pr.ed = gdbd_pkg::IN_DAY_W'(ed);
        pr.incl = incl;
        pr.drain = 1'b0;
        pending.push_back(pr);
    endtask

    task automatic pick_date(
        input  int unsigned                     lo,
        input  int unsigned                     hi,
        output logic [gdbd_pkg::IN_YEAR_W-1:0]  y,
        output logic [gdbd_pkg::IN_MONTH_W-1:0] m,
        output logic [gdbd_pkg::IN_DAY_W-1:0]   d
    );
        y = gdbd_pkg::IN_YEAR_W'($urandom_range(hi, lo));
        m = gdbd_pkg::IN_MONTH_W'($urandom_range(12, 1));
        d = gdbd_pkg::IN_DAY_W'($urandom_range(month_length(m, y), 1));
    endtask

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at result %0d: %s", received, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d counts still expected",
                     cycles, expected_counts.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver: offers pending pairs, records the expected count on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive
        bit idle;
        if (!rst_n)
        begin
            s_valid <= 1'b0;
            s_data  <= '0;
            s_user  <= '0;
        end
        else
        begin
            if (s_valid && s_ready)
            begin
                expected_counts.push_back(span_days(in_flight));
                accepted++;
            end
            if (!s_valid || s_ready)
            begin
                idle = (accepted < QUIET_LO || accepted >= QUIET_HI) &&
                       ($urandom_range(99) < 6);
                if (pending.size() == 0 || idle ||
                    (pending[0].drain && expected_counts.size() != 0))
                begin
                    s_valid <= 1'b0;
                end
                else
                begin
                    in_flight = pending.pop_front();
                    s_valid <= 1'b1;
                    // zero pad, end day, end month, end year, start day, start month, start year
                    s_data  <= {2'b00, in_flight.ed, in_flight.em, in_flight.ey,
                                in_flight.sd, in_flight.sm, in_flight.sy};
                    s_user  <= in_flight.incl;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each count word, drives ready with one long hold
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [gdbd_pkg::CNT_W-1:0] want;
        if (!rst_n)
        begin
            m_ready <= 1'b0;
        end
        else
        begin
            if (m_valid && m_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    flag_mismatch($sformatf("count %0d with nothing expected",
                                            m_data[gdbd_pkg::CNT_W-1:0]));
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (m_data[gdbd_pkg::CNT_W-1:0] !== want)
                    begin
                        flag_mismatch($sformatf("day_count %0d, expected %0d",
                                                m_data[gdbd_pkg::CNT_W-1:0], want));
                    end
                    if (m_data[gdbd_pkg::OUT_DATA_W-1:gdbd_pkg::CNT_W] !== '0)
                    begin
                        flag_mismatch($sformatf("pad bits %b not zero",
                                      m_data[gdbd_pkg::OUT_DATA_W-1:gdbd_pkg::CNT_W]));
                    end
                end
                received++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_ready <= 1'b0;
            end
            else if (received == HOLD_AT && !held)
            begin
                // sender keeps going, so the block backs up into its input
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end
            else
            begin
                m_ready <= (received >= QUIET_LO && received < QUIET_HI) ||
                           ($urandom_range(99) >= 6);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : run
        date_pair_t  pr;
        int unsigned r;
        int unsigned directed;

        // extremes of the range
        add_pair(1, 1, 1, MAX_YEAR, 12, 31, 1'b1);
        add_pair(1, 1, 1, MAX_YEAR, 12, 31, 1'b0);
        add_pair(MAX_YEAR, 12, 31, 1, 1, 1, 1'b0);
        add_pair(MAX_YEAR, 12, 31, 1, 1, 1, 1'b1);
        // equal dates
        add_pair(2024, 6, 15, 2024, 6, 15, 1'b0);
        add_pair(2024, 6, 15, 2024, 6, 15, 1'b1);
        // century and leap Februaries
        add_pair(1900, 2, 28, 1900, 3, 1, 1'b0);
        add_pair(2000, 2, 28, 2000, 3, 1, 1'b0);
        add_pair(2024, 2, 29, 2025, 2, 28, 1'b1);
        add_pair(2023, 2, 29, 2023, 3, 1, 1'b0);     // Feb 29 in a common year clamps to 28
        add_pair(2100, 2, 31, 2400, 2, 30, 1'b0);
        add_pair(1999, 12, 31, 2000, 1, 1, 1'b0);
        // clamped years, months and days
        add_pair(0, 0, 0, 16383, 15, 31, 1'b0);
        add_pair(16383, 15, 31, 0, 0, 0, 1'b1);
        add_pair(0, 1, 1, 1, 1, 2, 1'b0);
        add_pair(MAX_YEAR + 1, 12, 1, MAX_YEAR, 12, 31, 1'b0);
        add_pair(2023, 4, 31, 2023, 5, 1, 1'b0);     // day 31 in a 30-day month
        add_pair(2023, 13, 5, 2024, 0, 0, 1'b0);
        add_pair(0, 0, 0, 0, 0, 0, 1'b0);
        add_pair(500, 9, 0, 501, 9, 31, 1'b1);
        directed = pending.size();

        for (int unsigned i = 0; i < RANDOM_PAIRS; i++)
        begin
            r = $urandom_range(99);
            if (r < 25)
            begin
                // raw field bits, which may fall out of range
                pr.sy = gdbd_pkg::IN_YEAR_W'($urandom);
                pr.sm = gdbd_pkg::IN_MONTH_W'($urandom);
                pr.sd = gdbd_pkg::IN_DAY_W'($urandom);
                pr.ey = gdbd_pkg::IN_YEAR_W'($urandom);
                pr.em = gdbd_pkg::IN_MONTH_W'($urandom);
                pr.ed = gdbd_pkg::IN_DAY_W'($urandom);
            end
            else
            begin
                pick_date(1, MAX_YEAR, pr.sy, pr.sm, pr.sd);
                if (r < 65)
                begin
                    pick_date(pr.sy, (pr.sy + 2 > MAX_YEAR) ? MAX_YEAR : pr.sy + 2,
                              pr.ey, pr.em, pr.ed);
                end
                else
                begin
                    pick_date(1, MAX_YEAR, pr.ey, pr.em, pr.ed);
                end
            end
            pr.incl = 1'($urandom);
            pr.drain = (i == 0) || (i == RANDOM_PAIRS / 2);
            pending.push_back(pr);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_valid)
        begin
            @(posedge clk);
        end
        while (expected_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d date pairs (%0d directed, %0d random), checked %0d day counts",
                 accepted, directed, accepted - directed, received);
        $display("Covered clamped fields, leap and century Februaries, %0d-cycle hold",
                 HOLD_CYCLES);
        if (mismatches == 0 && expected_counts.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatches, %0d counts never seen", mismatches,
                     expected_counts.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
